// File: rtl/oia_pkg.sv
// Shared widths, reset values and codes for the operator input arbiter.
package oia_pkg;

  // field widths
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned POT_W      = 10;
  localparam int unsigned DZ_W       = 8;
  localparam int unsigned SPEED_W    = 15;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned DRIVE_W    = 16;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // deadzone high edge (centre plus deadzone) needs one bit over the reading
  localparam int unsigned HI_W = POT_W + 1;
  // interpolation numerator: offset (< 2^POT_W) times slope (< 2^SPEED_W)
  localparam int unsigned PROD_W = POT_W + SPEED_W;

  localparam int unsigned POT_FULL_SCALE_DEF = 1023;
  localparam int unsigned DRIVE_MAX          = 32767;

  // register reset values
  localparam logic [POT_W-1:0]   CENTER_LOW_RST  = 10'd502;
  localparam logic [POT_W-1:0]   CENTER_HIGH_RST = 10'd503;
  localparam logic [DZ_W-1:0]    DEADZONE_RST    = 8'd10;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST   = 15'd400;
  localparam logic [MS_W-1:0]    DEBOUNCE_RST    = 16'd25;
  localparam logic [MS_W-1:0]    SEND_IVL_RST    = 16'd50;

  // register indices
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_IVL    = 3'd5;

  // stop request codes
  localparam logic [CODE_W-1:0] STOP_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] STOP_LATCH = 2'd1;
  localparam logic [CODE_W-1:0] STOP_CLEAR = 2'd2;

  // active source codes
  localparam logic [CODE_W-1:0] SRC_NONE = 2'd0;
  localparam logic [CODE_W-1:0] SRC_POT  = 2'd1;
  localparam logic [CODE_W-1:0] SRC_UP   = 2'd2;
  localparam logic [CODE_W-1:0] SRC_DOWN = 2'd3;

  // winch codes
  localparam logic [CODE_W-1:0] WINCH_NONE = 2'd0;
  localparam logic [CODE_W-1:0] WINCH_UP   = 2'd1;
  localparam logic [CODE_W-1:0] WINCH_DOWN = 2'd2;

endpackage

// File: rtl/oia_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module oia_div #(
  parameter int unsigned DIVIDEND_W = oia_pkg::PROD_W,
  parameter int unsigned DIVISOR_W  = oia_pkg::MS_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // dividend bits shift out of the top of quo_q as quotient bits shift in
  assign rem_sh = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, dvs_q};
  assign fits   = ~diff[DIVISOR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEPS;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/operator_input_arbiter.sv
// Operator input arbiter: debounce, potentiometer mapping, source arbitration, send timing.
// Sequence: an accepted word goes straight to the finish state when the reading is in the
//   deadzone or the interpolation span is zero, else through start and wait around the divider.
// Flow: one word at a time; the finish state waits for room in the output register, and
//   the next word is taken once the result moves to the output register, which holds it.
// Reset: asynchronous, active low; registers to defaults, switches released, latch clear.
module operator_input_arbiter #(
  parameter int unsigned POT_FULL_SCALE = oia_pkg::POT_FULL_SCALE_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [oia_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [oia_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [oia_pkg::NOW_W-1:0]           now_ms_i,
  input  logic [oia_pkg::POT_W-1:0]           pot_raw_i,
  input  logic                                up_raw_pressed_i,
  input  logic                                down_raw_pressed_i,
  input  logic [oia_pkg::CODE_W-1:0]          stop_request_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [oia_pkg::DRIVE_W-1:0]  raw_drive_o,
  output logic signed [oia_pkg::DRIVE_W-1:0]  drive_out_o,
  output logic [oia_pkg::CODE_W-1:0]          winch_out_o,
  output logic [oia_pkg::CODE_W-1:0]          active_source_o,
  output logic                                stop_latched_o,
  output logic                                send_now_o,
  output logic [oia_pkg::SEQ_W-1:0]           packet_sequence_o
);

  // Span above the deadzone is full scale minus (high edge + 1). Its magnitude needs
  // the full-scale width, or HI_W bits when the high edge overshoots a small scale.
  localparam int unsigned FS_W   = $clog2(POT_FULL_SCALE + 1);
  localparam int unsigned SPAN_W = (FS_W > oia_pkg::HI_W) ? FS_W : oia_pkg::HI_W;
  localparam int unsigned SSW    = SPAN_W + 2;
  localparam logic signed [SSW-1:0] FULL_S = SSW'(POT_FULL_SCALE);

  // mapped value before clamping: quotient plus sign and offset
  localparam int unsigned VW = oia_pkg::PROD_W + 2;
  localparam logic signed [VW-1:0] V_MAX = VW'(oia_pkg::DRIVE_MAX);
  localparam logic signed [VW-1:0] V_MIN = -V_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    RG_ZERO,
    RG_BELOW,
    RG_ABOVE
  } region_e;

  state_e  state_q;

  // configuration registers
  logic [oia_pkg::POT_W-1:0]   center_low_q;
  logic [oia_pkg::POT_W-1:0]   center_high_q;
  logic [oia_pkg::DZ_W-1:0]    deadzone_q;
  logic [oia_pkg::SPEED_W-1:0] max_speed_q;
  logic [oia_pkg::MS_W-1:0]    debounce_q;
  logic [oia_pkg::MS_W-1:0]    send_ivl_q;

  // loop state
  logic [1:0]                  stable_q;
  logic [1:0]                  last_raw_q;
  logic [oia_pkg::NOW_W-1:0]   change_q [2];
  logic [oia_pkg::CODE_W-1:0]  src_q;
  logic                        stop_q;
  logic [oia_pkg::SEQ_W-1:0]   seq_q;
  logic [oia_pkg::NOW_W-1:0]   last_send_q;

  // per-word working registers
  region_e                     region_q;
  logic                        neg_q;
  logic                        span_zero_q;
  logic [oia_pkg::POT_W-1:0]   x_q;
  logic [SPAN_W-1:0]           divisor_q;
  logic                        send_pend_q;

  // output register
  logic                                out_valid_q;
  logic signed [oia_pkg::DRIVE_W-1:0]  raw_drive_q;
  logic signed [oia_pkg::DRIVE_W-1:0]  drive_q;
  logic [oia_pkg::CODE_W-1:0]          winch_q;
  logic [oia_pkg::CODE_W-1:0]          src_out_q;
  logic                                stop_out_q;
  logic                                send_out_q;
  logic [oia_pkg::SEQ_W-1:0]           seq_out_q;

  logic in_acc;
  logic out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------------
  // Debounce and send timing, settled at the accept edge
  // ---------------------------------------------------------------------------
  logic [1:0]                raw_lvl;
  logic [1:0]                stable_d;
  logic [oia_pkg::NOW_W-1:0] change_d [2];
  logic [oia_pkg::NOW_W-1:0] elapsed  [2];
  logic                      stop_d;
  logic                      send_due;
  logic [oia_pkg::NOW_W-1:0] since_send;

  assign raw_lvl = {down_raw_pressed_i, up_raw_pressed_i};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      // a level change restarts the hold timer
      change_d[i] = (raw_lvl[i] != last_raw_q[i]) ? now_ms_i : change_q[i];
      elapsed[i]  = now_ms_i - change_d[i];
      stable_d[i] = stable_q[i];
      if ((stable_q[i] != raw_lvl[i]) &&
          (elapsed[i] >= oia_pkg::NOW_W'(debounce_q))) begin
        stable_d[i] = raw_lvl[i];
      end
    end
  end

  always_comb begin
    unique case (stop_request_i)
      oia_pkg::STOP_LATCH: stop_d = 1'b1;
      oia_pkg::STOP_CLEAR: stop_d = 1'b0;
      default:             stop_d = stop_q;  // none, and the unused code
    endcase
  end

  // a zero last-send stamp means never sent
  assign since_send = now_ms_i - last_send_q;
  assign send_due   = (last_send_q == '0) ||
                      (since_send >= oia_pkg::NOW_W'(send_ivl_q));

  // ---------------------------------------------------------------------------
  // Deadzone classification and divider operands
  // ---------------------------------------------------------------------------
  logic signed [oia_pkg::HI_W:0]   lo_s;     // centre low minus deadzone, may be negative
  logic signed [oia_pkg::HI_W:0]   lo_m1;
  logic [oia_pkg::HI_W-1:0]        hi;       // centre high plus deadzone
  logic [oia_pkg::HI_W-1:0]        above_x;
  logic signed [SSW-1:0]           span_s;
  logic [SSW-1:0]                  span_mag;
  logic                            below;
  logic                            above;
  logic                            slope_neg;  // max speed of zero gives a slope of -1
  region_e                         region_d;
  logic                            neg_d;
  logic                            span_zero_d;
  logic [oia_pkg::POT_W-1:0]       x_d;
  logic [SPAN_W-1:0]               divisor_d;

  assign lo_s    = $signed({2'b0, center_low_q}) - $signed({4'b0, deadzone_q});
  assign lo_m1   = lo_s - (oia_pkg::HI_W + 1)'(1);
  assign hi      = {1'b0, center_high_q} + {3'b0, deadzone_q};
  assign above_x = {1'b0, pot_raw_i} - hi - oia_pkg::HI_W'(1);
  assign span_s  = FULL_S - $signed(SSW'(hi)) - SSW'(1);
  assign span_mag = span_s[SSW-1] ? SSW'(-span_s) : SSW'(span_s);
  assign below   = $signed({2'b0, pot_raw_i}) < lo_s;
  assign above   = {1'b0, pot_raw_i} > hi;
  assign slope_neg = (max_speed_q == '0);

  always_comb begin
    region_d    = RG_ZERO;
    neg_d       = 1'b0;
    span_zero_d = 1'b0;
    x_d         = pot_raw_i;
    divisor_d   = SPAN_W'(lo_m1[oia_pkg::POT_W-1:0]);
    if (below) begin
      region_d    = RG_BELOW;
      neg_d       = slope_neg;
      span_zero_d = (lo_m1 == '0);
    end else if (above) begin
      region_d    = RG_ABOVE;
      neg_d       = slope_neg ^ span_s[SSW-1];
      span_zero_d = (span_s == '0);
      x_d         = above_x[oia_pkg::POT_W-1:0];
      divisor_d   = span_mag[SPAN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Serial divider: |offset * slope| / |span|, truncated
  // ---------------------------------------------------------------------------
  logic [oia_pkg::SPEED_W-1:0] slope_mag;
  logic [oia_pkg::PROD_W-1:0]  numer;
  logic                        div_start;
  logic                        div_done;
  logic [oia_pkg::PROD_W-1:0]  div_quo;

  assign slope_mag = slope_neg ? oia_pkg::SPEED_W'(1) : (max_speed_q - oia_pkg::SPEED_W'(1));
  // product goes straight into the divider's register
  assign numer     = oia_pkg::PROD_W'(x_q) * oia_pkg::PROD_W'(slope_mag);
  assign div_start = (state_q == ST_START);

  oia_div #(
    .DIVIDEND_W (oia_pkg::PROD_W),
    .DIVISOR_W  (SPAN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numer),
    .divisor_i  (divisor_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Final value, clamp and arbitration
  // ---------------------------------------------------------------------------
  logic signed [VW-1:0]               q_s;
  logic signed [VW-1:0]               t_s;
  logic signed [VW-1:0]               m_s;
  logic signed [VW-1:0]               v_s;
  logic signed [oia_pkg::DRIVE_W-1:0] raw_cmd;
  logic [oia_pkg::CODE_W-1:0]         src_d;
  logic signed [oia_pkg::DRIVE_W-1:0] drive_d;
  logic [oia_pkg::CODE_W-1:0]         winch_d;

  assign q_s = $signed(VW'(div_quo));
  assign t_s = neg_q ? -q_s : q_s;
  assign m_s = $signed(VW'(max_speed_q));

  always_comb begin
    unique case (region_q)
      RG_BELOW: v_s = span_zero_q ? -m_s : (t_s - m_s);
      RG_ABOVE: v_s = span_zero_q ? VW'(1) : (t_s + VW'(1));
      default:  v_s = '0;
    endcase
  end

  always_comb begin
    if (v_s > V_MAX) begin
      raw_cmd = oia_pkg::DRIVE_W'(V_MAX);
    end else if (v_s < V_MIN) begin
      raw_cmd = oia_pkg::DRIVE_W'(V_MIN);
    end else begin
      raw_cmd = v_s[oia_pkg::DRIVE_W-1:0];
    end
  end

  // an active source holds until it goes idle; otherwise pot, up, down in that order
  always_comb begin
    src_d = src_q;
    unique case (src_q)
      oia_pkg::SRC_POT:  if (raw_cmd == '0) src_d = oia_pkg::SRC_NONE;
      oia_pkg::SRC_UP:   if (!stable_q[0]) src_d = oia_pkg::SRC_NONE;
      oia_pkg::SRC_DOWN: if (!stable_q[1]) src_d = oia_pkg::SRC_NONE;
      default: begin
        priority if (raw_cmd != '0) begin
          src_d = oia_pkg::SRC_POT;
        end else if (stable_q[0]) begin
          src_d = oia_pkg::SRC_UP;
        end else if (stable_q[1]) begin
          src_d = oia_pkg::SRC_DOWN;
        end else begin
          src_d = oia_pkg::SRC_NONE;
        end
      end
    endcase
  end

  // a latched stop zeroes drive and winch but not the reported source
  always_comb begin
    drive_d = '0;
    winch_d = oia_pkg::WINCH_NONE;
    if (!stop_q) begin
      unique case (src_d)
        oia_pkg::SRC_POT:  drive_d = raw_cmd;
        oia_pkg::SRC_UP:   winch_d = oia_pkg::WINCH_UP;
        oia_pkg::SRC_DOWN: winch_d = oia_pkg::WINCH_DOWN;
        default:           drive_d = '0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, configuration and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      center_low_q  <= oia_pkg::CENTER_LOW_RST;
      center_high_q <= oia_pkg::CENTER_HIGH_RST;
      deadzone_q    <= oia_pkg::DEADZONE_RST;
      max_speed_q   <= oia_pkg::MAX_SPEED_RST;
      debounce_q    <= oia_pkg::DEBOUNCE_RST;
      send_ivl_q    <= oia_pkg::SEND_IVL_RST;
      stable_q      <= '0;
      last_raw_q    <= '0;
      change_q[0]   <= '0;
      change_q[1]   <= '0;
      src_q         <= oia_pkg::SRC_NONE;
      stop_q        <= 1'b0;
      seq_q         <= '0;
      last_send_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          oia_pkg::CFG_CENTER_LOW:  center_low_q  <= cfg_wdata_i[oia_pkg::POT_W-1:0];
          oia_pkg::CFG_CENTER_HIGH: center_high_q <= cfg_wdata_i[oia_pkg::POT_W-1:0];
          oia_pkg::CFG_DEADZONE:    deadzone_q    <= cfg_wdata_i[oia_pkg::DZ_W-1:0];
          oia_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_wdata_i[oia_pkg::SPEED_W-1:0];
          oia_pkg::CFG_DEBOUNCE:    debounce_q    <= cfg_wdata_i[oia_pkg::MS_W-1:0];
          oia_pkg::CFG_SEND_IVL:    send_ivl_q    <= cfg_wdata_i[oia_pkg::MS_W-1:0];
          default: ;
        endcase
      end

      // a finished word refills the output register as the old one drains
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            stop_q      <= stop_d;
            stable_q    <= stable_d;
            last_raw_q  <= raw_lvl;
            change_q[0] <= change_d[0];
            change_q[1] <= change_d[1];
            if (send_due) begin
              seq_q       <= seq_q + oia_pkg::SEQ_W'(1);
              last_send_q <= now_ms_i;
            end
            // no division needed inside the deadzone or on a zero span
            if (region_d == RG_ZERO || span_zero_d) begin
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_START;
            end
          end
        end
        ST_START: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (div_done) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            src_q       <= src_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      region_q    <= region_d;
      neg_q       <= neg_d;
      span_zero_q <= span_zero_d;
      x_q         <= x_d;
      divisor_q   <= divisor_d;
      send_pend_q <= send_due;
    end
    if (state_q == ST_FIN && out_free) begin
      raw_drive_q <= raw_cmd;
      drive_q     <= drive_d;
      winch_q     <= winch_d;
      src_out_q   <= src_d;
      stop_out_q  <= stop_q;
      send_out_q  <= send_pend_q;
      seq_out_q   <= seq_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign raw_drive_o       = raw_drive_q;
  assign drive_out_o       = drive_q;
  assign winch_out_o       = winch_q;
  assign active_source_o   = src_out_q;
  assign stop_latched_o    = stop_out_q;
  assign send_now_o        = send_out_q;
  assign packet_sequence_o = seq_out_q;

`ifndef SYNTHESIS
  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_WAIT)
    else $error("divider finished outside the wait state");

  // a divider start is always followed by the wait state, with the divider not yet done
  a_start_only_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_WAIT && !div_done)
    else $error("divider start not followed by wait");

  // drive only flows from the pot source with no stop latched
  a_drive_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && drive_q != '0 |-> src_out_q == oia_pkg::SRC_POT && !stop_out_q)
    else $error("drive output while not pot source or stopped");

  // clamp keeps the most negative code out of the mapped value
  a_raw_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> raw_drive_q != {1'b1, {(oia_pkg::DRIVE_W-1){1'b0}}})
    else $error("mapped value outside clamp range");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the operator input arbiter: random and directed samples.
module testbench;
  import oia_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_500_000;
  localparam int unsigned N_PHASES       = 10;
  localparam int unsigned RAND_PER_PHASE = 163;
  localparam int unsigned LONG_HOLD      = 400;
  // drain margin after the slowest word, which runs through the serial divider
  localparam int unsigned DRAIN_CYCLES   = PROD_W + 8;
  // stop request code the block must ignore
  localparam logic [CODE_W-1:0] STOP_BOGUS = 2'd3;

  // one result word as the block reports it
  typedef struct {
    logic signed [DRIVE_W-1:0] raw_drive;
    logic signed [DRIVE_W-1:0] drive;
    logic [CODE_W-1:0]         winch;
    logic [CODE_W-1:0]         src;
    logic                      stop;
    logic                      send;
    logic [SEQ_W-1:0]          seq;
  } command_t;

  // Tracks the arbiter state per accepted sample and holds the commands still due.
  class command_tracker;
    logic [POT_W-1:0]   c_lo, c_hi;
    logic [DZ_W-1:0]    dz;
    logic [SPEED_W-1:0] vmax;
    logic [MS_W-1:0]    db_ms, ivl_ms;
    logic               stable [2];
    logic               last_lvl [2];
    logic [NOW_W-1:0]   chg_ms [2];
    logic [CODE_W-1:0]  src;
    logic               stopped;
    logic [SEQ_W-1:0]   seq;
    logic [NOW_W-1:0]   last_send;
    command_t           due_cmds [$];
    int                 errors;

    function new();
      c_lo      = CENTER_LOW_RST;
      c_hi      = CENTER_HIGH_RST;
      dz        = DEADZONE_RST;
      vmax      = MAX_SPEED_RST;
      db_ms     = DEBOUNCE_RST;
      ivl_ms    = SEND_IVL_RST;
      stable    = '{1'b0, 1'b0};
      last_lvl  = '{1'b0, 1'b0};
      chg_ms    = '{'0, '0};
      src       = SRC_NONE;
      stopped   = 1'b0;
      seq       = '0;
      last_send = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_CENTER_LOW:  c_lo   = val[POT_W-1:0];
        CFG_CENTER_HIGH: c_hi   = val[POT_W-1:0];
        CFG_DEADZONE:    dz     = val[DZ_W-1:0];
        CFG_MAX_SPEED:   vmax   = val[SPEED_W-1:0];
        CFG_DEBOUNCE:    db_ms  = val;
        CFG_SEND_IVL:    ivl_ms = val;
        default: ;
      endcase
    endfunction

    // straight-line interpolation, division truncates toward zero
    function longint interp(longint x, longint x0, longint x1, longint y0, longint y1);
      longint span;
      span = x1 - x0;
      if (span == 0) return y0;
      return (x - x0) * (y1 - y0) / span + y0;
    endfunction

    function logic signed [DRIVE_W-1:0] map_pot_drive(logic [POT_W-1:0] pot);
      longint m, lo, hi, r, v, lim;
      m   = longint'(vmax);
      lo  = longint'(c_lo) - longint'(dz);
      hi  = longint'(c_hi) + longint'(dz);
      r   = longint'(pot);
      lim = longint'(DRIVE_MAX);
      if (r >= lo && r <= hi) return '0;
      if (r < lo) v = interp(r, 0, lo - 1, -m, -1);
      else v = interp(r, hi + 1, longint'(POT_FULL_SCALE_DEF), 1, m);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v[DRIVE_W-1:0];
    endfunction

    function void debounce_switch(int i, logic lvl, logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] held;
      if (lvl != last_lvl[i]) begin
        last_lvl[i] = lvl;
        chg_ms[i]   = now;
      end
      held = now - chg_ms[i];
      if (stable[i] != lvl && held >= db_ms) stable[i] = lvl;
    endfunction

    function void take_sample(logic [NOW_W-1:0] now, logic [POT_W-1:0] pot, logic up,
                              logic dn, logic [CODE_W-1:0] req);
      command_t         c;
      logic [NOW_W-1:0] since;
      if (req == STOP_LATCH) stopped = 1'b1;
      else if (req == STOP_CLEAR) stopped = 1'b0;
      debounce_switch(0, up, now);
      debounce_switch(1, dn, now);
      c.raw_drive = map_pot_drive(pot);
      // an active source keeps the floor until it goes idle
      case (src)
        SRC_POT:  if (c.raw_drive == 0) src = SRC_NONE;
        SRC_UP:   if (!stable[0]) src = SRC_NONE;
        SRC_DOWN: if (!stable[1]) src = SRC_NONE;
        default: begin
          if (c.raw_drive != 0) src = SRC_POT;
          else if (stable[0]) src = SRC_UP;
          else if (stable[1]) src = SRC_DOWN;
          else src = SRC_NONE;
        end
      endcase
      c.drive = '0;
      c.winch = WINCH_NONE;
      if (!stopped) begin
        if (src == SRC_POT) c.drive = c.raw_drive;
        else if (src == SRC_UP) c.winch = WINCH_UP;
        else if (src == SRC_DOWN) c.winch = WINCH_DOWN;
      end
      since  = now - last_send;
      c.send = 1'b0;
      if (last_send == 0 || since >= ivl_ms) begin
        c.send    = 1'b1;
        seq       = seq + 1;
        last_send = now;
      end
      c.src  = src;
      c.stop = stopped;
      c.seq  = seq;
      due_cmds.push_back(c);
    endfunction

    function void diff(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      end
    endfunction

    function void match_command(command_t got);
      command_t want;
      if (due_cmds.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing outstanding", $time);
        return;
      end
      want = due_cmds.pop_front();
      diff("raw_drive", want.raw_drive, got.raw_drive);
      diff("drive_out", want.drive, got.drive);
      diff("winch_out", want.winch, got.winch);
      diff("active_source", want.src, got.src);
      diff("stop_latched", want.stop, got.stop);
      diff("send_now", want.send, got.send);
      diff("packet_sequence", want.seq, got.seq);
    endfunction

    function int outstanding();
      return due_cmds.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [NOW_W-1:0]           now_ms = '0;
  logic [POT_W-1:0]           pot_raw = '0;
  logic                       up_raw = 1'b0;
  logic                       down_raw = 1'b0;
  logic [CODE_W-1:0]          stop_req = STOP_NONE;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DRIVE_W-1:0]  raw_drive;
  logic signed [DRIVE_W-1:0]  drive_out;
  logic [CODE_W-1:0]          winch_out;
  logic [CODE_W-1:0]          active_source;
  logic                       stop_latched;
  logic                       send_now;
  logic [SEQ_W-1:0]           packet_sequence;

  command_tracker tracker;

  // shared between the stimulus and the result side
  bit               quiet = 1'b0;      // phase without idling on either side
  int               hold_asks = 0;     // bumped to ask the receiver for a long hold
  int unsigned      cycles = 0;
  logic [NOW_W-1:0] now_clk = '0;      // running sample timestamp
  logic [CFG_DATA_W-1:0] cur_cfg [6] = '{CFG_DATA_W'(CENTER_LOW_RST), CFG_DATA_W'(CENTER_HIGH_RST),
                                         CFG_DATA_W'(DEADZONE_RST), CFG_DATA_W'(MAX_SPEED_RST),
                                         DEBOUNCE_RST, SEND_IVL_RST};

  operator_input_arbiter i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .now_ms_i           (now_ms),
    .pot_raw_i          (pot_raw),
    .up_raw_pressed_i   (up_raw),
    .down_raw_pressed_i (down_raw),
    .stop_request_i     (stop_req),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .raw_drive_o        (raw_drive),
    .drive_out_o        (drive_out),
    .winch_out_o        (winch_out),
    .active_source_o    (active_source),
    .stop_latched_o     (stop_latched),
    .send_now_o         (send_now),
    .packet_sequence_o  (packet_sequence)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. Each word may be preceded by a random gap; valid stays high
  // across back-to-back words so it is never dropped and raised in one step.
  // Outputs are sampled right after the edge, i.e. the values the DUT saw.
  // ---------------------------------------------------------------------------
  task automatic offer(logic [NOW_W-1:0] now, logic [POT_W-1:0] pot, logic up, logic dn,
                       logic [CODE_W-1:0] req);
    int gap;
    int roll;
    gap  = 0;
    roll = $urandom_range(0, 99);
    if (!quiet) begin
      if (roll >= 95) gap = $urandom_range(10, 60);   // rare long pause
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= now;
    pot_raw  <= pot;
    up_raw   <= up;
    down_raw <= dn;
    stop_req <= req;
    do @(posedge clk); while (in_stall);
    tracker.take_sample(now, pot, up, dn, req);
  endtask

  // Stop offering and let every outstanding word come back, plus the
  // divider latency so the block is truly idle before a register write.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers back to back; the enable drops once at the end.
  task automatic load_config(logic [CFG_DATA_W-1:0] cl, logic [CFG_DATA_W-1:0] ch,
                             logic [CFG_DATA_W-1:0] dzc, logic [CFG_DATA_W-1:0] ms,
                             logic [CFG_DATA_W-1:0] db, logic [CFG_DATA_W-1:0] si);
    logic [CFG_IDX_W-1:0]  idx [6];
    logic [CFG_DATA_W-1:0] val [6];
    idx = '{CFG_CENTER_LOW, CFG_CENTER_HIGH, CFG_DEADZONE, CFG_MAX_SPEED, CFG_DEBOUNCE,
            CFG_SEND_IVL};
    val = '{cl, ch, dzc, ms, db, si};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      tracker.write_reg(idx[k], val[k]);
      cur_cfg[idx[k]] = val[k];
    end
    cfg_we <= 1'b0;
  endtask

  // Random samples shaped like real operation: time moves forward in small
  // steps scaled to the debounce time, switches hold their level for runs of
  // samples, the pot dwells in one region for a while. About a tenth of the
  // samples carry switch noise, and now and then the clock jumps anywhere.
  task automatic run_random(int n);
    int               lo, hi, e, step_max, pot_mode, roll;
    logic             up_lvl, dn_lvl, up, dn;
    logic [POT_W-1:0] pot, pot_hold;
    logic [CODE_W-1:0] req;
    up_lvl   = 1'b0;
    dn_lvl   = 1'b0;
    pot_mode = 0;
    pot_hold = '0;
    for (int i = 0; i < n; i++) begin
      lo = int'(cur_cfg[CFG_CENTER_LOW]) - int'(cur_cfg[CFG_DEADZONE]);
      hi = int'(cur_cfg[CFG_CENTER_HIGH]) + int'(cur_cfg[CFG_DEADZONE]);
      if (lo < 0) lo = 0;
      if (hi > 1023) hi = 1023;
      step_max = int'(cur_cfg[CFG_DEBOUNCE] >> 3) + 3;
      if ($urandom_range(0, 63) == 0) now_clk = $urandom;
      else now_clk = now_clk + $urandom_range(0, step_max);

      // pot: deadzone, anywhere, around the deadzone edges, or held still
      if ($urandom_range(0, 7) == 0) begin
        pot_mode = $urandom_range(0, 3);
        pot_hold = POT_W'($urandom);
      end
      case (pot_mode)
        0: pot = (lo <= hi) ? POT_W'($urandom_range(lo, hi)) : POT_W'($urandom);
        1: pot = POT_W'($urandom);
        2: begin
          case ($urandom_range(0, 3))
            0: e = lo - 1;
            1: e = lo;
            2: e = hi;
            default: e = hi + 1;
          endcase
          pot = (e < 0) ? '0 : (e > 1023) ? '1 : POT_W'(e);
        end
        default: pot = pot_hold;
      endcase

      if ($urandom_range(0, 9) == 0) begin
        up = 1'($urandom_range(0, 1));
        dn = 1'($urandom_range(0, 1));
      end else begin
        if ($urandom_range(0, 11) == 0) up_lvl = ~up_lvl;
        if ($urandom_range(0, 11) == 0) dn_lvl = ~dn_lvl;
        up = up_lvl;
        dn = dn_lvl;
      end

      // clears outnumber latches so the stop is not held most of the time
      roll = $urandom_range(0, 99);
      if (roll < 2) req = STOP_LATCH;
      else if (roll < 7) req = STOP_CLEAR;
      else if (roll == 7) req = STOP_BOGUS;
      else req = STOP_NONE;

      offer(now_clk, pot, up, dn, req);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: checks each accepted word, then picks the next stall.
  // A bump of hold_asks makes it stall for a long counted stretch so the
  // block fills and pushes back on the sender.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    command_t got;
    int       stall_left;
    int       seen_holds;
    int       roll;
    stall_left = 0;
    seen_holds = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.raw_drive = raw_drive;
        got.drive     = drive_out;
        got.winch     = winch_out;
        got.src       = active_source;
        got.stop      = stop_latched;
        got.send      = send_now;
        got.seq       = packet_sequence;
        tracker.match_command(got);
      end
      if (hold_asks != seen_holds) begin
        seen_holds = hold_asks;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) stall_left = $urandom_range(1, 3);
        else if (roll < 22) stall_left = $urandom_range(15, 70);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int cl, ch;
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at reset settings: deadzone 492..513, debounce 25 ms.
    offer(32'd0, 10'd502, 1'b0, 1'b0, STOP_NONE);    // first send, last send time stays zero
    offer(32'd1, 10'd0, 1'b0, 1'b0, STOP_NONE);      // full reverse, sends again
    offer(32'd2, 10'd1023, 1'b0, 1'b0, STOP_NONE);   // full forward, pot keeps the floor
    offer(32'd3, 10'd492, 1'b0, 1'b0, STOP_NONE);    // low deadzone edge gives zero
    offer(32'd4, 10'd491, 1'b0, 1'b0, STOP_NONE);    // one below the edge
    offer(32'd5, 10'd513, 1'b0, 1'b0, STOP_NONE);    // high deadzone edge
    offer(32'd6, 10'd514, 1'b0, 1'b0, STOP_NONE);    // one above the edge
    offer(32'd7, 10'd503, 1'b1, 1'b0, STOP_NONE);    // up pressed, still bouncing
    offer(32'd40, 10'd503, 1'b1, 1'b0, STOP_NONE);   // up accepted
    offer(32'd41, 10'd1023, 1'b1, 1'b0, STOP_NONE);  // pot locked out by up
    offer(32'd42, 10'd503, 1'b1, 1'b0, STOP_LATCH);  // stop zeroes the winch
    offer(32'd43, 10'd503, 1'b1, 1'b0, STOP_BOGUS);  // unknown request ignored
    offer(32'd44, 10'd503, 1'b1, 1'b0, STOP_CLEAR);
    offer(32'd45, 10'd503, 1'b0, 1'b1, STOP_NONE);
    offer(32'd80, 10'd503, 1'b0, 1'b1, STOP_NONE);   // up drops, source goes idle first
    offer(32'd81, 10'd503, 1'b0, 1'b1, STOP_NONE);   // then down takes over
    offer(32'd100, 10'd503, 1'b1, 1'b1, STOP_NONE);
    offer(32'hFFFF_FFF0, 10'd502, 1'b1, 1'b1, STOP_NONE);
    offer(32'hFFFF_FFFF, 10'd1023, 1'b1, 1'b1, STOP_NONE);
    offer(32'h0000_0000, 10'd502, 1'b0, 1'b0, STOP_NONE);  // wrap onto zero
    offer(32'd3, 10'd0, 1'b0, 1'b0, STOP_NONE);
    now_clk = 32'd3;
    run_random(RAND_PER_PHASE);

    // Later phases: sender pauses until all words are back, then new settings.
    for (int phase = 1; phase < N_PHASES; phase++) begin
      settle();
      quiet = (phase % 3 == 1);
      case (phase)
        1: load_config(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0);            // all minimum but a max speed of 1
        2: load_config(16'd1023, 16'd1023, 16'd255, 16'd32767, 16'hFFFF, 16'hFFFF);
        3: load_config(16'd1, 16'd1022, 16'd0, 16'd32767, 16'd10, 16'd5);    // zero spans
        4: load_config(16'd700, 16'd300, 16'd0, 16'd1000, 16'd20, 16'd30);   // crossed centre
        default: begin
          cl = $urandom_range(0, 1023);
          ch = $urandom_range(cl, (cl + 20 > 1023) ? 1023 : cl + 20);
          load_config(CFG_DATA_W'(cl), CFG_DATA_W'(ch), CFG_DATA_W'($urandom_range(0, 40)),
                      CFG_DATA_W'($urandom_range(1, 32767)), CFG_DATA_W'($urandom_range(0, 50)),
                      CFG_DATA_W'($urandom_range(0, 120)));
        end
      endcase
      if (phase == 2) hold_asks++;                 // receiver backs up the block
      if (phase == 6) now_clk = 32'hFFFF_FF00;      // cross the timestamp wrap
      run_random(RAND_PER_PHASE);
    end

    settle();
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/oia_pkg.sv
rtl/oia_div.sv
rtl/operator_input_arbiter.sv
tb/testbench.sv
